@@ hw/rtl/mhbp_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mhbp_pkg
// Shared codes, field widths and defaults for the max-heap build and pop block.
// ----------------------------------------------------------------------------
package mhbp_pkg;

    localparam int OP_W     = 2;
    localparam int KEY_W    = 8;
    localparam int RID_W    = 16;
    localparam int ENTRY_W  = KEY_W + RID_W;
    localparam int TOTAL_W  = 11;
    localparam int LEVEL_W  = 4;
    localparam int STATUS_W = 2;

    localparam int DEPTH_DEFAULT = 1024;

    localparam logic [OP_W-1:0] OP_APPEND = 2'd0;
    localparam logic [OP_W-1:0] OP_BUILD  = 2'd1;
    localparam logic [OP_W-1:0] OP_POP    = 2'd2;

    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

    function automatic logic [KEY_W-1:0] key_of(input logic [ENTRY_W-1:0] entry);
        return entry[ENTRY_W-1:RID_W];
    endfunction

endpackage

@@ hw/rtl/mhbp_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mhbp_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module mhbp_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ hw/rtl/max_heap_build_and_pop_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// max_heap_build_and_pop_top
// Array max-heap of (key, record id) words with append, build and pop.
// ----------------------------------------------------------------------------
// One word is in work at a time; the heap array lives in a single RAM with one
// write and one registered read port, and that read port sets the pace. Pop
// reads the root and then the last word, and sinks the moved word level by
// level, reading its children at each level. Build sinks each parent in turn,
// from the last parent back to the root. A new word is taken while the
// previous result still waits at the output register.
module max_heap_build_and_pop_top #(
    parameter int DEPTH = mhbp_pkg::DEPTH_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [mhbp_pkg::OP_W-1:0]     operation,
    input  logic [mhbp_pkg::KEY_W-1:0]    key,
    input  logic [mhbp_pkg::RID_W-1:0]    record_id,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [mhbp_pkg::KEY_W-1:0]    out_key,
    output logic [mhbp_pkg::RID_W-1:0]    out_record_id,
    output logic [mhbp_pkg::TOTAL_W-1:0]  entry_total,
    output logic [mhbp_pkg::LEVEL_W-1:0]  level_count,
    output logic [mhbp_pkg::STATUS_W-1:0] status
);

    import mhbp_pkg::*;

    localparam int AW  = $clog2(DEPTH);
    localparam int CW  = $clog2(DEPTH + 1);
    localparam int IW  = AW + 2;
    localparam int LVW = $clog2(CW + 1);

    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_POP_ROOT = 3'd1;
    localparam logic [2:0] ST_POP_LAST = 3'd2;
    localparam logic [2:0] ST_BLD_LOAD = 3'd3;
    localparam logic [2:0] ST_GETL     = 3'd4;
    localparam logic [2:0] ST_GETR     = 3'd5;
    localparam logic [2:0] ST_PLACE    = 3'd6;
    localparam logic [2:0] ST_DONE     = 3'd7;

    function automatic logic [LVW-1:0] levels_of(input logic [CW-1:0] n);
        logic [LVW-1:0] lv;
        lv = '0;
        for (int i = 0; i < CW; i++)
        begin
            if (n[i])
            begin
                lv = LVW'(i + 1);
            end
        end
        return lv;
    endfunction

    logic [2:0]          state_reg, state_next;
    logic [CW-1:0]       count_reg, count_next;
    logic [AW-1:0]       pos_reg, pos_next;
    logic [AW-1:0]       idx_reg, idx_next;
    logic [ENTRY_W-1:0]  hold_reg, hold_next;
    logic [ENTRY_W-1:0]  left_reg, left_next;
    logic                build_reg, build_next;
    logic [STATUS_W-1:0] stat_reg, stat_next;
    logic [KEY_W-1:0]    rkey_reg, rkey_next;
    logic [RID_W-1:0]    rrid_reg, rrid_next;

    logic                out_valid_reg, out_valid_next;
    logic [KEY_W-1:0]    out_key_reg, out_key_next;
    logic [RID_W-1:0]    out_rid_reg, out_rid_next;
    logic [TOTAL_W-1:0]  total_reg, total_next;
    logic [LEVEL_W-1:0]  level_reg, level_next;
    logic [STATUS_W-1:0] status_reg, status_next;

    logic                ram_we;
    logic [AW-1:0]       ram_waddr;
    logic [ENTRY_W-1:0]  ram_wdata;
    logic                ram_re;
    logic [AW-1:0]       ram_raddr;
    logic [ENTRY_W-1:0]  ram_rdata;

    logic [IW-1:0]       left_idx;
    logic [IW-1:0]       right_idx;
    logic [IW-1:0]       start_left;
    logic                do_decide;
    logic [ENTRY_W-1:0]  cand_entry;
    logic [IW-1:0]       cand_idx;
    logic                sift_start;
    logic [AW-1:0]       sift_from;
    logic                do_finish;

    mhbp_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH)
    ) u_heap_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign in_ready  = (state_reg == ST_IDLE);
    assign left_idx  = (IW'(pos_reg) << 1) + IW'(1);
    assign right_idx = left_idx + IW'(1);
    assign start_left = (IW'(sift_from) << 1) + IW'(1);

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        pos_next       = pos_reg;
        idx_next       = idx_reg;
        hold_next      = hold_reg;
        left_next      = left_reg;
        build_next     = build_reg;
        stat_next      = stat_reg;
        rkey_next      = rkey_reg;
        rrid_next      = rrid_reg;
        out_valid_next = out_valid_reg;
        out_key_next   = out_key_reg;
        out_rid_next   = out_rid_reg;
        total_next     = total_reg;
        level_next     = level_reg;
        status_next    = status_reg;
        ram_we         = 1'b0;
        ram_waddr      = pos_reg;
        ram_wdata      = hold_reg;
        ram_re         = 1'b0;
        ram_raddr      = '0;
        do_decide      = 1'b0;
        cand_entry     = left_reg;
        cand_idx       = left_idx;
        sift_start     = 1'b0;
        sift_from      = '0;
        do_finish      = 1'b0;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    stat_next  = STATUS_OK;
                    rkey_next  = '0;
                    rrid_next  = '0;
                    build_next = 1'b0;
                    state_next = ST_DONE;
                    unique case (operation)
                        OP_APPEND:
                        begin
                            if (count_reg >= CW'(DEPTH))
                            begin
                                stat_next = STATUS_FULL;
                            end
                            else
                            begin
                                ram_we     = 1'b1;
                                ram_waddr  = AW'(count_reg);
                                ram_wdata  = {key, record_id};
                                count_next = count_reg + CW'(1);
                            end
                        end
                        OP_BUILD:
                        begin
                            if (count_reg >= CW'(2))
                            begin
                                idx_next   = AW'((count_reg >> 1) - CW'(1));
                                ram_re     = 1'b1;
                                ram_raddr  = idx_next;
                                build_next = 1'b1;
                                state_next = ST_BLD_LOAD;
                            end
                        end
                        OP_POP:
                        begin
                            if (count_reg == '0)
                            begin
                                stat_next = STATUS_EMPTY;
                            end
                            else
                            begin
                                ram_re     = 1'b1;
                                ram_raddr  = '0;
                                state_next = ST_POP_ROOT;
                            end
                        end
                        default:
                        begin
                            stat_next = STATUS_OK;
                        end
                    endcase
                end
            end
            ST_POP_ROOT:
            begin
                rkey_next  = key_of(ram_rdata);
                rrid_next  = ram_rdata[RID_W-1:0];
                ram_re     = 1'b1;
                ram_raddr  = AW'(count_reg - CW'(1));
                state_next = ST_POP_LAST;
            end
            ST_POP_LAST:
            begin
                hold_next  = ram_rdata;
                count_next = count_reg - CW'(1);
                sift_start = 1'b1;
                sift_from  = '0;
            end
            ST_BLD_LOAD:
            begin
                hold_next  = ram_rdata;
                sift_start = 1'b1;
                sift_from  = idx_reg;
            end
            ST_GETL:
            begin
                left_next = ram_rdata;
                if (right_idx < IW'(count_reg))
                begin
                    ram_re     = 1'b1;
                    ram_raddr  = AW'(right_idx);
                    state_next = ST_GETR;
                end
                else
                begin
                    do_decide  = 1'b1;
                    cand_entry = ram_rdata;
                    cand_idx   = left_idx;
                end
            end
            ST_GETR:
            begin
                do_decide = 1'b1;
                if (key_of(ram_rdata) > key_of(left_reg))
                begin
                    cand_entry = ram_rdata;
                    cand_idx   = right_idx;
                end
                else
                begin
                    cand_entry = left_reg;
                    cand_idx   = left_idx;
                end
            end
            ST_PLACE:
            begin
                do_finish = 1'b1;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    out_key_next   = rkey_reg;
                    out_rid_next   = rrid_reg;
                    total_next     = TOTAL_W'(count_reg);
                    level_next     = LEVEL_W'(levels_of(count_reg));
                    status_next    = stat_reg;
                    state_next     = ST_IDLE;
                end
            end
        endcase

        // move the larger child up, or settle the held word here
        if (do_decide)
        begin
            if (key_of(cand_entry) > key_of(hold_reg))
            begin
                ram_we     = 1'b1;
                ram_waddr  = pos_reg;
                ram_wdata  = cand_entry;
                sift_start = 1'b1;
                sift_from  = AW'(cand_idx);
            end
            else
            begin
                do_finish = 1'b1;
            end
        end

        if (sift_start)
        begin
            pos_next = sift_from;
            if (start_left < IW'(count_next))
            begin
                ram_re     = 1'b1;
                ram_raddr  = AW'(start_left);
                state_next = ST_GETL;
            end
            else
            begin
                state_next = ST_PLACE;
            end
        end

        if (do_finish)
        begin
            ram_we    = 1'b1;
            ram_waddr = pos_reg;
            ram_wdata = hold_reg;
            if (build_reg && (idx_reg != '0))
            begin
                idx_next   = idx_reg - AW'(1);
                ram_re     = 1'b1;
                ram_raddr  = idx_next;
                state_next = ST_BLD_LOAD;
            end
            else
            begin
                state_next = ST_DONE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            build_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            build_reg     <= build_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg     <= pos_next;
        idx_reg     <= idx_next;
        hold_reg    <= hold_next;
        left_reg    <= left_next;
        stat_reg    <= stat_next;
        rkey_reg    <= rkey_next;
        rrid_reg    <= rrid_next;
        out_key_reg <= out_key_next;
        out_rid_reg <= out_rid_next;
        total_reg   <= total_next;
        level_reg   <= level_next;
        status_reg  <= status_next;
    end

    assign out_valid     = out_valid_reg;
    assign out_key       = out_key_reg;
    assign out_record_id = out_rid_reg;
    assign entry_total   = total_reg;
    assign level_count   = level_reg;
    assign status        = status_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("entry count beyond depth");

    a_read_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        ram_re |-> (IW'(ram_raddr) < IW'(count_reg)))
        else $error("read of an entry beyond the stored count");

    a_empty_total: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status == STATUS_EMPTY)) |-> (entry_total == '0))
        else $error("empty pop reported a non-zero total");

    a_full_total: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status == STATUS_FULL)) |-> (entry_total == TOTAL_W'(DEPTH)))
        else $error("full append reported a wrong total");

endmodule

@@ tb/sv/max_heap_build_and_pop_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// max_heap_build_and_pop_checker
// Watches both channels of the max-heap block. Keeps a mirror of the heap
// array and its count, and works out the result of every accepted word from
// that mirror. Each returned word is compared field by field with the oldest
// result still awaited. Hands the failure count and the number of results
// still awaited to the testbench top.
// ----------------------------------------------------------------------------
module max_heap_build_and_pop_checker #(
    parameter int DEPTH = mhbp_pkg::DEPTH_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic                          in_ready,
    input  logic [mhbp_pkg::OP_W-1:0]     operation,
    input  logic [mhbp_pkg::KEY_W-1:0]    key,
    input  logic [mhbp_pkg::RID_W-1:0]    record_id,
    input  logic                          out_valid,
    input  logic                          out_ready,
    input  logic [mhbp_pkg::KEY_W-1:0]    out_key,
    input  logic [mhbp_pkg::RID_W-1:0]    out_record_id,
    input  logic [mhbp_pkg::TOTAL_W-1:0]  entry_total,
    input  logic [mhbp_pkg::LEVEL_W-1:0]  level_count,
    input  logic [mhbp_pkg::STATUS_W-1:0] status,
    output int                            fail_count,
    output int                            pending
);

    import mhbp_pkg::*;

    typedef struct {
        logic [KEY_W-1:0]    key;
        logic [RID_W-1:0]    rid;
        logic [TOTAL_W-1:0]  total;
        logic [LEVEL_W-1:0]  levels;
        logic [STATUS_W-1:0] status;
    } heap_result_t;

    logic [ENTRY_W-1:0] heap_image [DEPTH];
    int unsigned        image_count = 0;
    heap_result_t       awaited_results [$];
    int                 misses = 0;

    function automatic void sink_from(input int unsigned pos);
        int unsigned        child;
        logic [ENTRY_W-1:0] held;
        while (2 * pos + 1 < image_count) begin
            child = 2 * pos + 1;
            if (child + 1 < image_count &&
                heap_image[child + 1][ENTRY_W-1:RID_W] > heap_image[child][ENTRY_W-1:RID_W])
                child = child + 1;
            if (heap_image[child][ENTRY_W-1:RID_W] <= heap_image[pos][ENTRY_W-1:RID_W])
                return;
            held             = heap_image[pos];
            heap_image[pos]  = heap_image[child];
            heap_image[child] = held;
            pos = child;
        end
    endfunction

    function automatic logic [LEVEL_W-1:0] height_of(input int unsigned n);
        int unsigned levels = 0;
        while (n != 0) begin
            levels++;
            n = n >> 1;
        end
        return levels[LEVEL_W-1:0];
    endfunction

    function automatic heap_result_t apply_word(input logic [OP_W-1:0] op,
                                                input logic [KEY_W-1:0] k,
                                                input logic [RID_W-1:0] rid);
        heap_result_t res = '{default: '0};
        res.status = STATUS_OK;
        case (op)
            OP_APPEND:
            begin
                if (image_count >= DEPTH)
                    res.status = STATUS_FULL;
                else
                begin
                    heap_image[image_count] = {k, rid};
                    image_count++;
                end
            end
            OP_BUILD:
            begin
                for (int p = int'(image_count / 2) - 1; p >= 0; p--)
                    sink_from(unsigned'(p));
            end
            OP_POP:
            begin
                if (image_count == 0)
                    res.status = STATUS_EMPTY;
                else
                begin
                    res.key = heap_image[0][ENTRY_W-1:RID_W];
                    res.rid = heap_image[0][RID_W-1:0];
                    image_count--;
                    heap_image[0] = heap_image[image_count];
                    sink_from(0);
                end
            end
            default:
            begin
            end
        endcase
        res.total  = image_count[TOTAL_W-1:0];
        res.levels = height_of(image_count);
        return res;
    endfunction

    function automatic string show(input heap_result_t r);
        return $sformatf("key %0d id 0x%04h total %0d levels %0d status %0d",
                         r.key, r.rid, r.total, r.levels, r.status);
    endfunction

    function automatic void note_failure(input string what);
        misses++;
        if (misses <= 10)
            $display("[%0t] mismatch: %s", $realtime, what);
    endfunction

    always @(posedge clk)
    begin
        heap_result_t want;
        heap_result_t got;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                got.key    = out_key;
                got.rid    = out_record_id;
                got.total  = entry_total;
                got.levels = level_count;
                got.status = status;
                if (awaited_results.size() == 0)
                    note_failure({"unexpected word: ", show(got)});
                else
                begin
                    want = awaited_results.pop_front();
                    if (got.key !== want.key || got.rid !== want.rid ||
                        got.total !== want.total || got.levels !== want.levels ||
                        got.status !== want.status)
                        note_failure({"expected ", show(want), " got ", show(got)});
                end
            end
            if (in_valid && in_ready)
                awaited_results.push_back(apply_word(operation, key, record_id));
        end
        fail_count <= misses;
        pending    <= awaited_results.size();
    end

endmodule

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the max-heap build and pop block. Drives a directed run over
// the empty, single-entry, equal-children and unordered-append cases, then
// random load/build/drain runs mixed with noise, and finally fills the heap to
// the limit. Idling on both channels changes in three phases. A checker beside
// the block predicts and compares every returned word.
// ----------------------------------------------------------------------------
module tb_top;
    import mhbp_pkg::*;

    localparam int              DEPTH        = DEPTH_DEFAULT;
    localparam logic [OP_W-1:0] OP_UNUSED    = 2'd3;
    localparam int              RANDOM_WORDS = 60;
    localparam int              QUIET_LIMIT  = 100000;

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                in_valid  = 1'b0;
    logic [OP_W-1:0]     operation = OP_APPEND;
    logic [KEY_W-1:0]    key       = '0;
    logic [RID_W-1:0]    record_id = '0;
    logic                out_ready = 1'b0;
    logic                in_ready;
    logic                out_valid;
    logic [KEY_W-1:0]    out_key;
    logic [RID_W-1:0]    out_record_id;
    logic [TOTAL_W-1:0]  entry_total;
    logic [LEVEL_W-1:0]  level_count;
    logic [STATUS_W-1:0] status;

    int fail_count;
    int pending;
    int tx_idle_pct = 20;
    int rx_idle_pct = 68;
    int fill_level  = 0;
    int quiet       = 0;

    max_heap_build_and_pop_top #(
        .DEPTH(DEPTH)
    ) u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .operation    (operation),
        .key          (key),
        .record_id    (record_id),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_key      (out_key),
        .out_record_id(out_record_id),
        .entry_total  (entry_total),
        .level_count  (level_count),
        .status       (status)
    );

    max_heap_build_and_pop_checker #(
        .DEPTH(DEPTH)
    ) u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .operation    (operation),
        .key          (key),
        .record_id    (record_id),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_key      (out_key),
        .out_record_id(out_record_id),
        .entry_total  (entry_total),
        .level_count  (level_count),
        .status       (status),
        .fail_count   (fail_count),
        .pending      (pending)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end

    initial
    begin
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic logic [KEY_W-1:0] pick_key();
        if ($urandom_range(0, 99) < 30)
            return KEY_W'($urandom_range(0, 7));
        return KEY_W'($urandom_range(0, 255));
    endfunction

    function automatic logic [RID_W-1:0] pick_rid();
        return RID_W'($urandom_range(0, 65535));
    endfunction

    task automatic send_word(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] k,
                             input logic [RID_W-1:0] rid);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        operation <= op;
        key       <= k;
        record_id <= rid;
        do @(posedge clk); while (!in_ready);
        case (op)
            OP_APPEND: if (fill_level < DEPTH) fill_level++;
            OP_POP:    if (fill_level > 0) fill_level--;
            default:
            begin
            end
        endcase
    endtask

    initial
    begin
        int unsigned shape;
        int unsigned loads;
        int unsigned drops;
        int          random_words;
        logic [OP_W-1:0] op;

        random_words = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_word(OP_POP, 8'hFF, 16'hFFFF);
        send_word(OP_BUILD, 8'hFF, 16'hFFFF);
        send_word(OP_UNUSED, 8'hFF, 16'hFFFF);
        send_word(OP_APPEND, 8'h00, 16'h0000);
        send_word(OP_BUILD, 8'h00, 16'h0000);
        send_word(OP_POP, 8'h00, 16'h0000);
        send_word(OP_APPEND, 8'd10, 16'h0001);
        send_word(OP_APPEND, 8'd50, 16'h0002);
        send_word(OP_APPEND, 8'd50, 16'h0003);
        send_word(OP_BUILD, 8'h00, 16'h0000);
        send_word(OP_POP, 8'h00, 16'h0000);
        send_word(OP_APPEND, 8'hFF, 16'hFFFF);
        send_word(OP_APPEND, 8'd128, 16'hAAAA);
        send_word(OP_APPEND, 8'd127, 16'h5555);
        repeat (6) send_word(OP_POP, 8'h00, 16'h0000);

        while (random_words < RANDOM_WORDS)
        begin
            if (random_words >= 2 * RANDOM_WORDS / 3)
            begin
                tx_idle_pct <= 0;
                rx_idle_pct <= 0;
            end
            else if (random_words >= RANDOM_WORDS / 3)
            begin
                tx_idle_pct <= 68;
                rx_idle_pct <= 20;
            end
            shape = $urandom_range(0, 99);
            if (shape < 55)
            begin
                loads = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 200)
                                                    : $urandom_range(1, 40);
                repeat (loads) send_word(OP_APPEND, pick_key(), pick_rid());
                send_word(OP_BUILD, pick_key(), pick_rid());
                drops = (fill_level > 300) ? fill_level : $urandom_range(0, fill_level + 1);
                repeat (drops) send_word(OP_POP, pick_key(), pick_rid());
                random_words += loads + drops + 1;
            end
            else if (shape < 75)
            begin
                loads = $urandom_range(1, 8);
                drops = $urandom_range(1, 8);
                repeat (loads) send_word(OP_APPEND, pick_key(), pick_rid());
                repeat (drops) send_word(OP_POP, pick_key(), pick_rid());
                random_words += loads + drops;
            end
            else
            begin
                op = OP_W'($urandom_range(0, 3));
                send_word(op, pick_key(), pick_rid());
                random_words++;
            end
        end

        tx_idle_pct <= 0;
        rx_idle_pct <= 0;
        while (fill_level < DEPTH)
            send_word(OP_APPEND, pick_key(), pick_rid());
        repeat (3) send_word(OP_APPEND, pick_key(), pick_rid());
        send_word(OP_BUILD, 8'h00, 16'h0000);
        send_word(OP_POP, 8'h00, 16'h0000);
        repeat (2) send_word(OP_APPEND, pick_key(), pick_rid());
        repeat (12) send_word(OP_POP, 8'h00, 16'h0000);

        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (40) @(posedge clk);
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

@@ files.f @@
hw/rtl/mhbp_pkg.sv
hw/rtl/mhbp_ram.sv
hw/rtl/max_heap_build_and_pop_top.sv
tb/sv/max_heap_build_and_pop_checker.sv
tb/sv/tb_top.sv
